// ===== rtl/htlru_pkg.sv =====
// shared types and constants for the lru get-or-insert hash table
// no dependencies

package htlru_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int HASH_SLOTS_DEF = 512;
  localparam int KEY_W          = 32;
  localparam int TIME_W         = 48;
  localparam int SLOT_OUT_W     = 8;

  localparam logic [KEY_W-1:0] HASH_MUL = 32'd2654435761;
  localparam logic [KEY_W-1:0] KEY_NONE = '0;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_ms;
  } htlru_req_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  inserted;
    logic                  evicted;
    logic [KEY_W-1:0]      evicted_key;
    logic [TIME_W-1:0]     first_seen;
    logic                  bad_key;
  } htlru_res_t;

endpackage

// ===== rtl/htlru_ram.sv =====
// single-port-write, single-port-read synchronous ram, registered read data
// depends on htlru_pkg for default sizes

module htlru_ram
  import htlru_pkg::*;
#(
  parameter int W = KEY_W,
  parameter int D = HASH_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/hash_table_lru_get_or_insert_core.sv =====
// top level: sequencer for the lru get-or-insert hash table
// depends on htlru_pkg and htlru_ram (bucket index ram and slot entry ram)
// a zero key is flagged from idle and never raises busy; any other key keeps busy high until the
//   result strobe: a hit probes, then refreshes its slot; a miss probes, fills a free slot and
//   probes again to insert, a full table first adding the lru scan, a probe to drop the old key
//   and a reinsert probe per cluster bucket moved; one transaction at a time, no receiver stall
// reset: asynchronous, then a pass over every bucket clears the bucket ram with busy high

module hash_table_lru_get_or_insert_core
  import htlru_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  htlru_req_t req_i,
  output logic       done_o,
  output htlru_res_t res_o
);

  localparam int SW  = $clog2(CAPACITY);
  localparam int HB  = $clog2(HASH_SLOTS);
  localparam int PW  = $clog2(HASH_SLOTS + 1);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int BW  = KEY_W + SW;
  localparam int EW  = KEY_W + 2 * TIME_W;
  localparam int SOW = (SW < SLOT_OUT_W) ? SW : SLOT_OUT_W;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_HASH, ST_P_RD, ST_P_CHK, ST_HIT, ST_WRSLOT,
    ST_MV_RD, ST_MV_CHK, ST_SCAN, ST_SCEND
  } state_e;

  // what the current probe is for
  typedef enum logic [1:0] {
    PR_LOOK, PR_DROP, PR_MOVE, PR_INS
  } pur_e;

  state_e state_q;
  pur_e   pur_q;

  logic [KEY_W-1:0]  key_q, pk_q, mk_q, evk_q, bkey_q;
  logic [TIME_W-1:0] now_q, best_q;
  logic [HB-1:0]     pb_q, j_q, clr_q;
  logic [PW-1:0]     pn_q, jn_q;
  logic [SW-1:0]     ms_q, s_q, ri_q, bidx_q;
  logic [CW-1:0]     used_q, sc_q;
  logic              ev_q, rv_q, bv_q, done_q;
  htlru_res_t        res_q;

  // bucket ram: {key, slot}
  logic          b_we, b_re;
  logic [HB-1:0] b_waddr, b_raddr;
  logic [BW-1:0] b_wdata, b_rdata;
  logic [KEY_W-1:0] bk;
  logic [SW-1:0]    bs;

  // slot ram: {key, first seen, last seen}
  logic          s_we, s_re;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [EW-1:0] s_wdata, s_rdata;
  logic [KEY_W-1:0]  sk;
  logic [TIME_W-1:0] sfirst, slast;

  logic [KEY_W-1:0] hprod;
  logic             pdone, pmatch;

  assign bk     = b_rdata[BW-1:SW];
  assign bs     = b_rdata[SW-1:0];
  assign sk     = s_rdata[EW-1:2*TIME_W];
  assign sfirst = s_rdata[2*TIME_W-1:TIME_W];
  assign slast  = s_rdata[TIME_W-1:0];

  // home bucket hash, registered before the probe starts
  assign hprod  = pk_q * HASH_MUL;

  // probe ends at a match, at an empty bucket, or after the full probe length
  assign pmatch = (bk == pk_q);
  assign pdone  = (bk == KEY_NONE) || pmatch || (pn_q == PW'(HASH_SLOTS));

  htlru_ram #(.W(BW), .D(HASH_SLOTS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  htlru_ram #(.W(EW), .D(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // memory port steering
  always_comb begin
    b_we    = 1'b0;
    b_waddr = pb_q;
    b_wdata = '0;
    b_re    = 1'b0;
    b_raddr = pb_q;
    s_we    = 1'b0;
    s_waddr = s_q;
    s_wdata = {key_q, now_q, now_q};
    s_re    = 1'b0;
    s_raddr = bs;
    unique case (state_q)
      ST_CLR: begin
        b_we    = 1'b1;
        b_waddr = clr_q;
      end
      ST_P_RD: begin
        b_re = 1'b1;
      end
      ST_P_CHK: begin
        if (!pdone) begin
          // next bucket of the probe, back to back
          b_re    = 1'b1;
          b_raddr = pb_q + 1'b1;
        end else begin
          unique case (pur_q)
            PR_LOOK: s_re = pmatch;
            PR_DROP: b_we = pmatch;
            PR_MOVE: begin
              b_we    = 1'b1;
              b_wdata = {mk_q, ms_q};
            end
            PR_INS: begin
              b_we    = 1'b1;
              b_wdata = {key_q, s_q};
            end
          endcase
        end
      end
      ST_HIT: begin
        // refresh last seen, keep key and first seen
        s_we    = 1'b1;
        s_wdata = {sk, sfirst, now_q};
      end
      ST_WRSLOT: begin
        s_we = 1'b1;
      end
      ST_MV_RD: begin
        b_re    = (jn_q != PW'(HASH_SLOTS));
        b_raddr = j_q;
      end
      ST_MV_CHK: begin
        // lift the cluster entry out before it is reinserted
        b_we    = (bk != KEY_NONE);
        b_waddr = j_q;
      end
      ST_SCAN: begin
        s_re    = (sc_q < CW'(CAPACITY));
        s_raddr = sc_q[SW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      pur_q   <= PR_LOOK;
      clr_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
      rv_q    <= 1'b0;
      bv_q    <= 1'b0;
      ev_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == HB'(HASH_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (req_i.key == KEY_NONE) begin
              // zero key: flag it, touch nothing
              done_q <= 1'b1;
              res_q  <= '{slot: '0, inserted: 1'b0, evicted: 1'b0,
                          evicted_key: KEY_NONE, first_seen: '0, bad_key: 1'b1};
            end else begin
              key_q   <= req_i.key;
              now_q   <= req_i.now_ms;
              pk_q    <= req_i.key;
              pur_q   <= PR_LOOK;
              ev_q    <= 1'b0;
              evk_q   <= KEY_NONE;
              state_q <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          pb_q    <= hprod[HB-1:0];
          pn_q    <= PW'(1);
          state_q <= ST_P_RD;
        end
        ST_P_RD: begin
          state_q <= ST_P_CHK;
        end
        ST_P_CHK: begin
          if (!pdone) begin
            pb_q <= pb_q + 1'b1;
            pn_q <= pn_q + 1'b1;
          end else begin
            unique case (pur_q)
              PR_LOOK: begin
                if (pmatch) begin
                  s_q     <= bs;
                  state_q <= ST_HIT;
                end else if (used_q < CW'(CAPACITY)) begin
                  // slots are never freed, so the lowest free slot is the fill count
                  s_q     <= used_q[SW-1:0];
                  used_q  <= used_q + 1'b1;
                  state_q <= ST_WRSLOT;
                end else begin
                  sc_q    <= '0;
                  rv_q    <= 1'b0;
                  bv_q    <= 1'b0;
                  state_q <= ST_SCAN;
                end
              end
              PR_DROP: begin
                if (pmatch) begin
                  j_q     <= pb_q + 1'b1;
                  jn_q    <= '0;
                  state_q <= ST_MV_RD;
                end else begin
                  state_q <= ST_WRSLOT;
                end
              end
              PR_MOVE: begin
                j_q     <= j_q + 1'b1;
                jn_q    <= jn_q + 1'b1;
                state_q <= ST_MV_RD;
              end
              PR_INS: begin
                done_q            <= 1'b1;
                res_q.slot        <= SLOT_OUT_W'(s_q[SOW-1:0]);
                res_q.inserted    <= 1'b1;
                res_q.evicted     <= ev_q;
                res_q.evicted_key <= evk_q;
                res_q.first_seen  <= now_q;
                res_q.bad_key     <= 1'b0;
                state_q           <= ST_IDLE;
              end
            endcase
          end
        end
        ST_HIT: begin
          done_q            <= 1'b1;
          res_q.slot        <= SLOT_OUT_W'(s_q[SOW-1:0]);
          res_q.inserted    <= 1'b0;
          res_q.evicted     <= 1'b0;
          res_q.evicted_key <= KEY_NONE;
          res_q.first_seen  <= sfirst;
          res_q.bad_key     <= 1'b0;
          state_q           <= ST_IDLE;
        end
        ST_WRSLOT: begin
          pk_q    <= key_q;
          pur_q   <= PR_INS;
          state_q <= ST_HASH;
        end
        ST_MV_RD: begin
          if (jn_q == PW'(HASH_SLOTS)) begin
            state_q <= ST_WRSLOT;
          end else begin
            state_q <= ST_MV_CHK;
          end
        end
        ST_MV_CHK: begin
          if (bk == KEY_NONE) begin
            state_q <= ST_WRSLOT;
          end else begin
            mk_q    <= bk;
            ms_q    <= bs;
            pk_q    <= bk;
            pur_q   <= PR_MOVE;
            state_q <= ST_HASH;
          end
        end
        ST_SCAN: begin
          // one read issued per cycle, compare on the returning data
          if (sc_q < CW'(CAPACITY)) begin
            sc_q <= sc_q + 1'b1;
          end
          rv_q <= (sc_q < CW'(CAPACITY));
          ri_q <= sc_q[SW-1:0];
          if (rv_q && (!bv_q || (slast < best_q))) begin
            best_q <= slast;
            bidx_q <= ri_q;
            bkey_q <= sk;
            bv_q   <= 1'b1;
          end
          if (sc_q == CW'(CAPACITY)) begin
            state_q <= ST_SCEND;
          end
        end
        ST_SCEND: begin
          s_q     <= bidx_q;
          evk_q   <= bkey_q;
          ev_q    <= 1'b1;
          pk_q    <= bkey_q;
          pur_q   <= PR_DROP;
          state_q <= ST_HASH;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.bad_key |-> (res_o.slot == '0) && !res_o.inserted &&
      !res_o.evicted && (res_o.evicted_key == KEY_NONE) && (res_o.first_seen == '0))
    else $error("zero key result carries data");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.evicted |-> res_o.inserted && (used_q == CW'(CAPACITY)))
    else $error("eviction without a full table");

  a_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.evicted == (res_o.evicted_key != KEY_NONE)))
    else $error("evicted key disagrees with evicted flag");

  a_seq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.bad_key |-> $past(busy))
    else $error("lookup result without a busy sequence");
`endif

endmodule
